// ===== rtl/fti_pkg.sv =====
// ----------------------------------------------------------------------------
// Fuzzy two-input inference package
// Widths, set corners, reciprocal constants and the payload types that
// travel between the pipeline stages of the inference block.
// ----------------------------------------------------------------------------
package fti_pkg;

    // Field and bus widths.
    localparam int LEVEL_W   = 10;
    localparam int ALARM_W   = 11;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Internal value widths.
    localparam int GRADE_W   = 10;
    localparam int WHI_W     = 12;
    localparam int WMD_W     = 11;
    localparam int NUM_W     = 23;
    localparam int DEN_W     = 13;
    localparam int DIV_W     = NUM_W + 1;
    localparam int QUOT_W    = 11;
    localparam int DIV_STEPS = QUOT_W;

    // Ramp arithmetic: grade = (dist * 1000 * M) >> SHIFT, exact for all ramp points.
    localparam int DIST_W      = 8;
    localparam int RECIP_W     = 28;
    localparam int PROD_W      = DIST_W + RECIP_W;
    localparam int RECIP_SHIFT = 26;

    // 1000 * ceil(2^26 / 255) and 1000 * ceil(2^26 / 251).
    localparam logic [RECIP_W-1:0] RECIP_255 = 28'd263173000;
    localparam logic [RECIP_W-1:0] RECIP_251 = 28'd267366000;

    // Set corners that fall inside the 10-bit sample range.
    localparam logic [LEVEL_W-1:0] LOW_KNEE  = 10'd259;
    localparam logic [LEVEL_W-1:0] MID_PEAK  = 10'd514;
    localparam logic [LEVEL_W-1:0] HIGH_KNEE = 10'd765;

    localparam logic [GRADE_W-1:0] GRADE_FULL = 10'd1000;
    localparam logic [GRADE_W-1:0] GRADE_NONE = 10'd0;

    // Result when no rule fires.
    localparam logic [ALARM_W-1:0] ALARM_NONE = 11'd514;

    // Ramp products for one sample.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PROD_W-1:0]  p_low_fall;
        logic [PROD_W-1:0]  p_med_rise;
        logic [PROD_W-1:0]  p_med_fall;
        logic [PROD_W-1:0]  p_high_rise;
    } ramp_prod_t;

    typedef struct packed {
        ramp_prod_t flame;
        ramp_prod_t smoke;
    } prod_pair_t;

    // Membership grades for one sample.
    typedef struct packed {
        logic [GRADE_W-1:0] low;
        logic [GRADE_W-1:0] med;
        logic [GRADE_W-1:0] high;
    } grade_set_t;

    typedef struct packed {
        grade_set_t flame;
        grade_set_t smoke;
    } grade_pair_t;

    // Rule strengths summed per output centroid.
    typedef struct packed {
        logic [WHI_W-1:0]   w_hi;
        logic [WMD_W-1:0]   w_md;
        logic [GRADE_W-1:0] w_lo;
    } rule_sum_t;

    // Weighted sum and total weight ahead of the divider.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             none;
    } frac_t;

    // One step of the long division.
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [QUOT_W-1:0] quot;
        logic              none;
    } div_stage_t;

endpackage

// ===== rtl/fuzzy_two_input_inference.sv =====
// ----------------------------------------------------------------------------
// Fuzzy two-input inference
// Grades a flame and a smoke sample in low, medium and high sets, applies six
// min rules and returns the weighted average of the rule centroids.
//
//  Channel   Dir  Width  Contents (lowest bit first)
//  s_axis    in   24     flame_level[9:0], smoke_level[19:10], zero pad
//  m_axis    out  16     alarm_level[10:0], zero pad
//
// One item enters per cycle while the output takes results. The pipeline has
// two grading stages, two rule stages, eleven divider steps (one quotient
// bit each) and the output register. Every stage holds its own valid bit and
// loads whenever it is empty or its item moves on, so a stalled output only
// backs up as far as the pipeline is full. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module fuzzy_two_input_inference
    import fti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // flame_level, smoke_level
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // alarm_level
);

    logic               grade_valid;
    logic               grade_ready;
    grade_pair_t        grades;
    logic               frac_valid;
    logic               frac_ready;
    frac_t              frac;
    logic [ALARM_W-1:0] alarm_level;

    // Membership grading.
    fti_grade u_grade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .flame     (s_axis_tdata[LEVEL_W-1:0]),
        .smoke     (s_axis_tdata[2*LEVEL_W-1:LEVEL_W]),
        .out_valid (grade_valid),
        .out_ready (grade_ready),
        .grades    (grades)
    );

    // Rule strengths and weighted sum.
    fti_rules u_rules (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grade_valid),
        .in_ready  (grade_ready),
        .grades    (grades),
        .out_valid (frac_valid),
        .out_ready (frac_ready),
        .frac      (frac)
    );

    // Weighted average.
    fti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frac_valid),
        .in_ready  (frac_ready),
        .frac      (frac),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .alarm     (alarm_level)
    );

    assign m_axis_tdata = M_TDATA_W'(alarm_level);

endmodule

// ===== rtl/fti_grade.sv =====
// ----------------------------------------------------------------------------
// Fuzzy inference membership grading
// Two stages: ramp distances times the scaled reciprocal, then region
// selection of the low, medium and high grades for both samples.
// ----------------------------------------------------------------------------
module fti_grade
    import fti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LEVEL_W-1:0] flame,
    input  logic [LEVEL_W-1:0] smoke,
    output logic               out_valid,
    input  logic               out_ready,
    output grade_pair_t        grades
);

    // Distances to the four ramp corners, each scaled by 1000/length.
    function automatic ramp_prod_t ramp_products(input logic [LEVEL_W-1:0] x);
        ramp_prod_t         r;
        logic [LEVEL_W-1:0] d_low_fall;
        logic [LEVEL_W-1:0] d_med_rise;
        logic [LEVEL_W-1:0] d_med_fall;
        logic [LEVEL_W-1:0] d_high_rise;
        d_low_fall    = MID_PEAK - x;
        d_med_rise    = x - LOW_KNEE;
        d_med_fall    = HIGH_KNEE - x;
        d_high_rise   = x - MID_PEAK;
        r.level       = x;
        r.p_low_fall  = PROD_W'(d_low_fall[DIST_W-1:0]) * PROD_W'(RECIP_255);
        r.p_med_rise  = PROD_W'(d_med_rise[DIST_W-1:0]) * PROD_W'(RECIP_255);
        r.p_med_fall  = PROD_W'(d_med_fall[DIST_W-1:0]) * PROD_W'(RECIP_251);
        r.p_high_rise = PROD_W'(d_high_rise[DIST_W-1:0]) * PROD_W'(RECIP_251);
        return r;
    endfunction

    // Pick each grade by the region the sample falls in.
    function automatic grade_set_t select_grades(input ramp_prod_t r);
        grade_set_t g;
        logic       le_knee;
        logic       lt_peak;
        logic       lt_high;
        le_knee = (r.level <= LOW_KNEE);
        lt_peak = (r.level < MID_PEAK);
        lt_high = (r.level < HIGH_KNEE);

        if (le_knee)
            g.low = GRADE_FULL;
        else if (lt_peak)
            g.low = r.p_low_fall[RECIP_SHIFT +: GRADE_W];
        else
            g.low = GRADE_NONE;

        if (le_knee || !lt_high)
            g.med = GRADE_NONE;
        else if (lt_peak)
            g.med = r.p_med_rise[RECIP_SHIFT +: GRADE_W];
        else if (r.level == MID_PEAK)
            g.med = GRADE_FULL;
        else
            g.med = r.p_med_fall[RECIP_SHIFT +: GRADE_W];

        if (r.level <= MID_PEAK)
            g.high = GRADE_NONE;
        else if (lt_high)
            g.high = r.p_high_rise[RECIP_SHIFT +: GRADE_W];
        else
            g.high = GRADE_FULL;
        return g;
    endfunction

    logic        prod_valid_reg;
    prod_pair_t  prod_reg;
    prod_pair_t  prod_next;
    logic        prod_ready;
    logic        grade_valid_reg;
    grade_pair_t grade_reg;
    grade_pair_t grade_next;
    logic        grade_ready;

    // Each stage loads when it is empty or its contents move on.
    assign grade_ready = !grade_valid_reg || out_ready;
    assign prod_ready  = !prod_valid_reg || grade_ready;
    assign in_ready    = prod_ready;

    // Stage one: ramp products.
    always_comb
    begin
        prod_next.flame = ramp_products(flame);
        prod_next.smoke = ramp_products(smoke);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (prod_ready)
            prod_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid)
            prod_reg <= prod_next;
    end

    // Stage two: grade selection.
    always_comb
    begin
        grade_next.flame = select_grades(prod_reg.flame);
        grade_next.smoke = select_grades(prod_reg.smoke);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grade_valid_reg <= 1'b0;
        else if (grade_ready)
            grade_valid_reg <= prod_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (grade_ready && prod_valid_reg)
            grade_reg <= grade_next;
    end

    assign out_valid = grade_valid_reg;
    assign grades    = grade_reg;

endmodule

// ===== rtl/fti_rules.sv =====
// ----------------------------------------------------------------------------
// Fuzzy inference rule evaluation
// Two stages: minimum of each rule's grades summed per centroid, then the
// weighted sum and total weight for the divider.
// ----------------------------------------------------------------------------
module fti_rules
    import fti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  grade_pair_t grades,
    output logic        out_valid,
    input  logic        out_ready,
    output frac_t       frac
);

    function automatic logic [GRADE_W-1:0] min_grade(input logic [GRADE_W-1:0] a,
                                                     input logic [GRADE_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic      sum_valid_reg;
    rule_sum_t sum_reg;
    rule_sum_t sum_next;
    logic      sum_ready;
    logic      frac_valid_reg;
    frac_t     frac_reg;
    frac_t     frac_next;
    logic      frac_ready;

    assign frac_ready = !frac_valid_reg || out_ready;
    assign sum_ready  = !sum_valid_reg || frac_ready;
    assign in_ready   = sum_ready;

    // Stage one: rule strengths grouped by output centroid.
    always_comb
    begin
        sum_next.w_hi = WHI_W'(min_grade(grades.flame.low, grades.smoke.high))
                      + WHI_W'(min_grade(grades.flame.med, grades.smoke.high))
                      + WHI_W'(min_grade(grades.flame.high, grades.smoke.high));
        sum_next.w_md = WMD_W'(min_grade(grades.flame.low, grades.smoke.med))
                      + WMD_W'(min_grade(grades.flame.med, grades.smoke.med));
        sum_next.w_lo = min_grade(grades.flame.low, grades.smoke.low);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else if (sum_ready)
            sum_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && in_valid)
            sum_reg <= sum_next;
    end

    // Stage two: high weight times 1024 plus medium weight times 514.
    always_comb
    begin
        frac_next.num  = NUM_W'({sum_reg.w_hi, 10'b0})
                       + NUM_W'({sum_reg.w_md, 9'b0})
                       + NUM_W'({sum_reg.w_md, 1'b0});
        frac_next.den  = DEN_W'(sum_reg.w_hi) + DEN_W'(sum_reg.w_md)
                       + DEN_W'(sum_reg.w_lo);
        frac_next.none = (sum_reg.w_hi == '0) && (sum_reg.w_md == '0)
                      && (sum_reg.w_lo == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_valid_reg <= 1'b0;
        else if (frac_ready)
            frac_valid_reg <= sum_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (frac_ready && sum_valid_reg)
            frac_reg <= frac_next;
    end

    assign out_valid = frac_valid_reg;
    assign frac      = frac_reg;

endmodule

// ===== rtl/fti_div.sv =====
// ----------------------------------------------------------------------------
// Fuzzy inference pipelined divider
// Restoring long division, one quotient bit per stage, followed by an
// output register that substitutes the no-rule result.
// ----------------------------------------------------------------------------
module fti_div
    import fti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  frac_t              frac,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ALARM_W-1:0] alarm
);

    div_stage_t         stage_reg   [DIV_STEPS];
    div_stage_t         stage_next  [DIV_STEPS];
    div_stage_t         stage_in    [DIV_STEPS];
    logic               valid_reg   [DIV_STEPS];
    logic               valid_in    [DIV_STEPS];
    logic               stage_ready [DIV_STEPS];
    logic               alarm_valid_reg;
    logic [ALARM_W-1:0] alarm_reg;
    logic [ALARM_W-1:0] alarm_next;
    logic               alarm_ready;

    // Ready chain from the output register back to the first step.
    assign alarm_ready = !alarm_valid_reg || out_ready;

    always_comb
    begin
        stage_ready[DIV_STEPS-1] = !valid_reg[DIV_STEPS-1] || alarm_ready;
        for (int k = DIV_STEPS - 2; k >= 0; k--)
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
    end

    assign in_ready = stage_ready[0];

    // First step takes the numerator as its partial remainder.
    always_comb
    begin
        stage_in[0].rem  = frac.num;
        stage_in[0].den  = frac.den;
        stage_in[0].quot = '0;
        stage_in[0].none = frac.none;
        valid_in[0]      = in_valid;
    end

    for (genvar k = 1; k < DIV_STEPS; k++)
    begin : g_link
        assign stage_in[k] = stage_reg[k-1];
        assign valid_in[k] = valid_reg[k-1];
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int BIT = DIV_STEPS - 1 - k;
        logic [DIV_W-1:0] trial;
        logic [DIV_W-1:0] diff;

        // Subtract the shifted divisor where it fits.
        assign trial = DIV_W'(stage_in[k].den) << BIT;
        assign diff  = DIV_W'(stage_in[k].rem) - trial;

        always_comb
        begin
            stage_next[k] = stage_in[k];
            if (DIV_W'(stage_in[k].rem) >= trial)
            begin
                stage_next[k].rem       = diff[NUM_W-1:0];
                stage_next[k].quot[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (stage_ready[k])
                valid_reg[k] <= valid_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[k] && valid_in[k])
                stage_reg[k] <= stage_next[k];
        end
    end

    // Output register: quotient, or the fixed level when no rule fired.
    assign alarm_next = stage_reg[DIV_STEPS-1].none ? ALARM_NONE
                                                    : stage_reg[DIV_STEPS-1].quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alarm_valid_reg <= 1'b0;
        else if (alarm_ready)
            alarm_valid_reg <= valid_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (alarm_ready && valid_reg[DIV_STEPS-1])
            alarm_reg <= alarm_next;
    end

    assign out_valid = alarm_valid_reg;
    assign alarm     = alarm_reg;

endmodule

// ===== rtl/fti_checker.sv =====
// ----------------------------------------------------------------------------
// Fuzzy inference port checker
// Watches the top-level ports for reset, stall and result-range behavior.
// ----------------------------------------------------------------------------
module fti_checker
    import fti_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // No item is shown while reset is held.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result shown during reset");

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Results stay within the centroid range and the pad bits stay zero.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:ALARM_W] == '0)
                       && (m_axis_tdata[ALARM_W-1:0] <= 11'd1024))
        else $error("result out of range");

    // With the output side taking items, the input side never stalls.
    a_no_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // The empty pipeline takes an item in the first cycle after reset.
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind fuzzy_two_input_inference fti_checker u_fti_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
